@@ sv/sdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpc_pkg
// Types, constants and register map of the slew duty profile controller.
// ----------------------------------------------------------------------------
package sdpc_pkg;

   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int DUTY_WIDTH_DEF  = 10;
   localparam int CSR_ADDR_WIDTH  = 5;

   typedef enum logic [2:0] {
      REG_ACCEL_ANGLE     = 3'd0,
      REG_MIN_DUTY        = 3'd1,
      REG_MAX_DUTY        = 3'd2,
      REG_TOLERANCE       = 3'd3,
      REG_STALL_PERIOD    = 3'd4,
      REG_STALL_THRESHOLD = 3'd5,
      REG_DESTALL_DUTY    = 3'd6,
      REG_DESTALL_TRIES   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_START     = 2'd0,
      KIND_SAMPLE    = 2'd1,
      KIND_INTERRUPT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_ACCEL   = 2'd0,
      PHASE_PLATEAU = 2'd1,
      PHASE_DECEL   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_MOVING    = 3'd1,
      ST_REACHED   = 3'd2,
      ST_EARLY     = 3'd3,
      ST_STALLED   = 3'd4,
      ST_WRONG_DIR = 3'd5,
      ST_EMERGENCY = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] target_angle;
      logic signed [15:0] angle;
   } req_type;

   typedef struct packed {
      logic [9:0] duty;
      logic       motor_on;
      logic       direction_negative;
      logic [1:0] phase;
      logic       destall;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [14:0] accel_angle;
      logic [9:0]  min_duty;
      logic [9:0]  max_duty;
      logic [14:0] tolerance;
      logic [15:0] stall_period;
      logic [14:0] stall_threshold;
      logic [9:0]  destall_duty;
      logic [3:0]  destall_tries;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // latch request, compute remaining distances
      logic div_go;   // start rounding divider
      logic finish;   // commit the result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage

@@ sv/slew_duty_profile_controller_top.sv @@
// Slew duty profile controller. Each transfer on req_ carries a start, an
// angle sample or an interrupt and yields one transfer on rsp_. Starts,
// interrupts and unknown kinds pass from acceptance through the finish state
// to rsp_valid; samples first pass the multiply and select states and the
// 48-step bit-serial rounding divider of the ramp duty. One item is in flight
// at a time; a new item is taken the cycle after the result transfer.
// ----------------------------------------------------------------------------
// slew_duty_profile_controller_top
// Top level: register port, sequencer and ramp datapath.
// ----------------------------------------------------------------------------
module slew_duty_profile_controller_top #(
   parameter int ANGLE_WIDTH = sdpc_pkg::ANGLE_WIDTH_DEF,
   parameter int DUTY_WIDTH  = sdpc_pkg::DUTY_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sdpc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sdpc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sdpc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import sdpc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   sdpc_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg(cfg)
   );

   sdpc_controller u_ctrl (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall,
      .cmd(cmd), .sts(sts)
   );

   sdpc_datapath #(.ANGLE_WIDTH(ANGLE_WIDTH), .DUTY_WIDTH(DUTY_WIDTH)) u_dp (
      .clock, .reset, .cfg(cfg), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp(rsp_data)
   );

endmodule

@@ sv/sdpc_datapath.sv @@
// ----------------------------------------------------------------------------
// sdpc_datapath
// Slew state, ramp arithmetic with a bit-serial rounding divider, result.
// ----------------------------------------------------------------------------
module sdpc_datapath #(
   parameter int ANGLE_WIDTH = sdpc_pkg::ANGLE_WIDTH_DEF,
   parameter int DUTY_WIDTH  = sdpc_pkg::DUTY_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  sdpc_pkg::cfg_type cfg,
   input  sdpc_pkg::req_type req,
   input  sdpc_pkg::cmd_type cmd,
   output sdpc_pkg::sts_type sts,
   output sdpc_pkg::rsp_type rsp
);
   import sdpc_pkg::*;

   localparam int AW = ANGLE_WIDTH;   // angle field width
   localparam int DW = DUTY_WIDTH;    // duty field width
   localparam int PW = 48;   // numerator width
   localparam int QW = 34;   // quotient width
   localparam int CW = $clog2(QW + 1);
   localparam logic signed [AW+1:0] ANG_MAX = (AW+2)'((64'sd1 <<< (AW-1)) - 64'sd1);
   localparam logic signed [AW+1:0] ANG_MIN = -ANG_MAX - (AW+2)'(1);

   logic                 active_ff, dir_neg_ff, intr_ff;
   logic signed [AW-1:0] start_ff, goal_ff, check_ff, last_angle_ff;
   logic signed [AW:0]   last_ramp_ff;
   logic [15:0]          ticks_ff;
   logic [3:0]           stalls_ff;
   phase_type            last_phase_ff;
   logic [DW-1:0]        last_duty_ff;

   req_type              req_ff;
   logic signed [AW+1:0] up_ff, left_ff;
   logic signed [PW-1:0] nup_ff, ndn_ff;
   logic                 sel_down_ff;
   logic                 neg_ff;
   logic [PW-1:0]        num_ff;
   logic [PW-1:0]        rem_ff;
   logic [QW-1:0]        quo_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff, step_ff;

   logic [14:0]          acc;
   logic signed [11:0]   span;
   logic [24:0]          base_p;
   logic signed [PW-1:0] base;
   logic signed [AW+1:0] up_c, left_c;
   logic signed [AW+1:0] diff_dn;
   logic signed [AW+13:0] pup_c, pdn_c;

   assign acc    = (cfg.accel_angle == '0) ? 15'd1 : cfg.accel_angle;
   assign span   = $signed({2'b00, cfg.max_duty}) - $signed({2'b00, cfg.min_duty});
   assign base_p = cfg.min_duty * acc;
   assign base   = $signed({{(PW-25){1'b0}}, base_p});

   assign up_c   = dir_neg_ff ? (AW+2)'(start_ff) - (AW+2)'(req.angle)
                              : (AW+2)'(req.angle) - (AW+2)'(start_ff);
   assign left_c = dir_neg_ff ? (AW+2)'(req.angle) - (AW+2)'(goal_ff)
                              : (AW+2)'(goal_ff) - (AW+2)'(req.angle);
   assign diff_dn = left_ff - $signed({3'b000, cfg.tolerance});

   assign pup_c = up_ff * span;
   assign pdn_c = diff_dn * span;

   // divider: magnitude of numerator, 2*mag + d over 2*d, restoring
   logic signed [PW-1:0] n_sel;
   logic [PW-1:0]        n_abs;
   logic [PW-1:0]        mag2;
   logic [PW-1:0]        rem_sh, d2;
   assign n_sel  = (sel_down_ff ? ndn_ff : nup_ff) + base;
   assign n_abs  = (n_sel < 0) ? PW'(-n_sel) : PW'(n_sel);
   assign mag2   = {n_abs[PW-2:0], 1'b0} + PW'(acc);
   assign d2     = PW'({acc, 1'b0});
   assign rem_sh = {rem_ff[PW-2:0], num_ff[PW-1]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req;
         up_ff   <= up_c;
         left_ff <= left_c;
      end
      if (step_ff) begin
         nup_ff <= PW'(pup_c);
         ndn_ff <= PW'(pdn_c);
      end
      if (cmd.div_go) begin
         sel_down_ff <= !(nup_ff <= ndn_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
      end else begin
         step_ff <= cmd.load;
      end
   end

   // divider: go latches selection, prep loads the numerator, then iterate
   logic prep_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         prep_ff <= cmd.div_go;
         if (prep_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(PW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ff) begin
         neg_ff <= n_sel < 0;
         num_ff <= mag2;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[PW-2:0], 1'b0};
         if (rem_sh >= d2) begin
            rem_ff <= rem_sh - d2;
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
      end
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(1));
      end
   end
   assign sts.div_done = done_ff;

   // final evaluation
   logic signed [QW:0]   q_s;
   logic signed [QW:0]   duty_c;
   phase_type            ph_c;
   logic [DW-1:0]        duty_f;
   logic [AW:0]          chg_mag;
   logic signed [AW:0]   chg;
   rsp_type              out_c;
   logic                 active_in, intr_in;
   logic signed [AW-1:0] goal_in, start_in, check_in, last_angle_in;
   logic signed [AW:0]   last_ramp_in;
   logic [15:0]          ticks_in;
   logic [3:0]           stalls_in;
   phase_type            last_phase_in;
   logic [DW-1:0]        last_duty_in;
   logic                 dir_in;
   logic signed [AW+1:0] rt;
   logic [15:0]          tick1;
   rsp_type              rsp_ff;

   assign q_s = {1'b0, quo_ff};
   assign chg = (AW+1)'(req_ff.angle) - (AW+1)'(check_ff);
   assign chg_mag = chg < 0 ? (AW+1)'(-chg) : (AW+1)'(chg);
   assign tick1 = ticks_ff + 16'd1;

   always_comb begin
      duty_c = neg_ff ? -q_s : q_s;
      ph_c   = sel_down_ff ? PHASE_DECEL : PHASE_ACCEL;
      if (duty_c < $signed({{(QW-9){1'b0}}, cfg.min_duty})) begin
         duty_c = $signed({{(QW-9){1'b0}}, cfg.min_duty});
      end else if (duty_c >= $signed({{(QW-9){1'b0}}, cfg.max_duty})) begin
         ph_c   = PHASE_PLATEAU;
         duty_c = $signed({{(QW-9){1'b0}}, cfg.max_duty});
      end
      duty_f = duty_c[DW-1:0];
   end

   always_comb begin
      active_in     = active_ff;
      intr_in       = intr_ff;
      goal_in       = goal_ff;
      start_in      = start_ff;
      check_in      = check_ff;
      last_angle_in = last_angle_ff;
      last_ramp_in  = last_ramp_ff;
      ticks_in      = ticks_ff;
      stalls_in     = stalls_ff;
      last_phase_in = last_phase_ff;
      last_duty_in  = last_duty_ff;
      dir_in        = dir_neg_ff;
      rt            = '0;
      out_c         = '0;
      out_c.phase   = last_phase_ff;
      out_c.status  = active_ff ? ST_MOVING : ST_IDLE;
      if (active_ff) begin
         out_c.duty     = last_duty_ff;
         out_c.motor_on = 1'b1;
      end
      case (kind_type'(req_ff.kind))
         KIND_START: begin
            goal_in       = req_ff.target_angle;
            start_in      = req_ff.angle;
            dir_in        = !(req_ff.target_angle > req_ff.angle);
            check_in      = req_ff.angle;
            ticks_in      = '0;
            stalls_in     = cfg.destall_tries;
            intr_in       = 1'b0;
            last_phase_in = PHASE_ACCEL;
            last_angle_in = req_ff.angle;
            last_ramp_in  = '0;
            last_duty_in  = '0;
            active_in     = 1'b1;
            out_c         = '0;
            out_c.motor_on = 1'b1;
            out_c.status   = ST_MOVING;
         end
         KIND_INTERRUPT: begin
            if (active_ff) begin
               if (intr_ff) begin
                  active_in = 1'b0;
                  out_c.duty = '0;
                  out_c.motor_on = 1'b0;
                  out_c.status = ST_EMERGENCY;
               end else begin
                  intr_in = 1'b1;
                  if (last_phase_ff == PHASE_ACCEL) begin
                     rt = dir_neg_ff ? (AW+2)'(last_angle_ff) - (AW+2)'(last_ramp_ff)
                                     : (AW+2)'(last_angle_ff) + (AW+2)'(last_ramp_ff);
                  end else begin
                     rt = dir_neg_ff
                        ? (AW+2)'(last_angle_ff) - $signed({3'b000, cfg.accel_angle})
                        : (AW+2)'(last_angle_ff) + $signed({3'b000, cfg.accel_angle});
                  end
                  if (last_phase_ff == PHASE_ACCEL || last_phase_ff == PHASE_PLATEAU) begin
                     if (rt > ANG_MAX) goal_in = ANG_MAX[AW-1:0];
                     else if (rt < ANG_MIN) goal_in = ANG_MIN[AW-1:0];
                     else goal_in = rt[AW-1:0];
                  end
               end
            end
         end
         KIND_SAMPLE: begin
            if (active_ff) begin
               if (left_ff < $signed({3'b000, cfg.tolerance})) begin
                  active_in = 1'b0;
                  out_c.duty = '0;
                  out_c.motor_on = 1'b0;
                  out_c.status = intr_ff ? ST_EARLY : ST_REACHED;
               end else begin
                  last_phase_in = ph_c;
                  last_angle_in = req_ff.angle;
                  last_ramp_in  = up_ff[AW:0];
                  last_duty_in  = duty_f;
                  out_c.duty    = duty_f;
                  out_c.phase   = ph_c;
                  ticks_in      = tick1;
                  if (tick1 >= cfg.stall_period) begin
                     check_in = req_ff.angle;
                     ticks_in = '0;
                     if (chg_mag < {2'b00, cfg.stall_threshold}) begin
                        if (stalls_ff != '0) begin
                           stalls_in     = stalls_ff - 4'd1;
                           out_c.duty    = cfg.destall_duty;
                           out_c.destall = 1'b1;
                        end else begin
                           active_in = 1'b0;
                           out_c.duty = '0;
                           out_c.motor_on = 1'b0;
                           out_c.phase = last_phase_ff;
                           out_c.status = ST_STALLED;
                        end
                     end else if ((chg < 0) != dir_neg_ff) begin
                        active_in = 1'b0;
                        out_c.duty = '0;
                        out_c.motor_on = 1'b0;
                        out_c.phase = last_phase_ff;
                        out_c.status = ST_WRONG_DIR;
                     end else begin
                        stalls_in = '0;
                     end
                  end
                  if (!active_in) begin
                     out_c.phase = ph_c;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      out_c.direction_negative = dir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         dir_neg_ff    <= 1'b0;
         intr_ff       <= 1'b0;
         start_ff      <= '0;
         goal_ff       <= '0;
         check_ff      <= '0;
         last_angle_ff <= '0;
         last_ramp_ff  <= '0;
         ticks_ff      <= '0;
         stalls_ff     <= '0;
         last_phase_ff <= PHASE_ACCEL;
         last_duty_ff  <= '0;
      end else if (cmd.finish) begin
         active_ff     <= active_in;
         dir_neg_ff    <= dir_in;
         intr_ff       <= intr_in;
         start_ff      <= start_in;
         goal_ff       <= goal_in;
         check_ff      <= check_in;
         last_angle_ff <= last_angle_in;
         last_ramp_ff  <= last_ramp_in;
         ticks_ff      <= ticks_in;
         stalls_ff     <= stalls_in;
         last_phase_ff <= last_phase_in;
         last_duty_ff  <= last_duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= out_c;
      end
   end
   assign rsp = rsp_ff;

endmodule

@@ sv/sdpc_controller.sv @@
// ----------------------------------------------------------------------------
// sdpc_controller
// Sequencer: accept, ramp computation, division, result handoff.
// ----------------------------------------------------------------------------
module sdpc_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sdpc_pkg::cmd_type cmd,
   input  sdpc_pkg::sts_type sts
);
   import sdpc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_SEL  = 6'b000100,
      S_DIV  = 6'b001000,
      S_FIN  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      is_sample;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign is_sample = (req_data.kind == KIND_SAMPLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = is_sample ? S_MUL : S_FIN;
            end
         end
         S_MUL: state_in = S_SEL;
         S_SEL: begin
            cmd.div_go = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: if (sts.div_done) state_in = S_FIN;
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/sdpc_csr.sv @@
// ----------------------------------------------------------------------------
// sdpc_csr
// APB-style register file for the ramp and stall settings.
// ----------------------------------------------------------------------------
module sdpc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sdpc_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output sdpc_pkg::cfg_type                    cfg
);
   import sdpc_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type idx;

   assign idx    = reg_index_type'(paddr[4:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_angle     <= 15'd640;
         cfg_ff.min_duty        <= 10'd100;
         cfg_ff.max_duty        <= 10'd1023;
         cfg_ff.tolerance       <= 15'd6;
         cfg_ff.stall_period    <= 16'd100;
         cfg_ff.stall_threshold <= 15'd6;
         cfg_ff.destall_duty    <= 10'd1023;
         cfg_ff.destall_tries   <= 4'd3;
      end else if (psel && penable && pwrite) begin
         case (idx)
            REG_ACCEL_ANGLE:     cfg_ff.accel_angle     <= pwdata[14:0];
            REG_MIN_DUTY:        cfg_ff.min_duty        <= pwdata[9:0];
            REG_MAX_DUTY:        cfg_ff.max_duty        <= pwdata[9:0];
            REG_TOLERANCE:       cfg_ff.tolerance       <= pwdata[14:0];
            REG_STALL_PERIOD:    cfg_ff.stall_period    <= pwdata[15:0];
            REG_STALL_THRESHOLD: cfg_ff.stall_threshold <= pwdata[14:0];
            REG_DESTALL_DUTY:    cfg_ff.destall_duty    <= pwdata[9:0];
            REG_DESTALL_TRIES:   cfg_ff.destall_tries   <= pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (idx)
         REG_ACCEL_ANGLE:     prdata = 32'(cfg_ff.accel_angle);
         REG_MIN_DUTY:        prdata = 32'(cfg_ff.min_duty);
         REG_MAX_DUTY:        prdata = 32'(cfg_ff.max_duty);
         REG_TOLERANCE:       prdata = 32'(cfg_ff.tolerance);
         REG_STALL_PERIOD:    prdata = 32'(cfg_ff.stall_period);
         REG_STALL_THRESHOLD: prdata = 32'(cfg_ff.stall_threshold);
         REG_DESTALL_DUTY:    prdata = 32'(cfg_ff.destall_duty);
         REG_DESTALL_TRIES:   prdata = 32'(cfg_ff.destall_tries);
         default:             prdata = '0;
      endcase
   end

endmodule

@@ sv/sdpc_checker.sv @@
// ----------------------------------------------------------------------------
// sdpc_checker
// Port-level checks on the slew duty profile controller.
// ----------------------------------------------------------------------------
module sdpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sdpc_pkg::rsp_type rsp_data
);
   import sdpc_pkg::*;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.motor_on |-> rsp_data.duty == '0)
      else $error("nonzero duty with motor off");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_kick_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.destall |-> rsp_data.motor_on
         && rsp_data.status == ST_MOVING)
      else $error("kick pulse without moving status");

endmodule

bind slew_duty_profile_controller_top sdpc_checker u_sdpc_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

@@ bench/slew_duty_profile_controller_top_tb.sv @@
// ----------------------------------------------------------------------------
// slew_duty_profile_controller_top_tb
// Self-checking bench for the slew duty profile controller. A directed table
// covers idle items, extreme angles, both directions, the reached and
// emergency stops and the interrupt retarget. Random slews follow, each a
// start and a run of samples toward the target, with stalls, reversals,
// interrupts and noise mixed in, over several register settings. Every
// response is checked against its typed row or a built-in duty predictor.
// ----------------------------------------------------------------------------
module slew_duty_profile_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sdpc_pkg::*;

   localparam int  LIMIT   = 3000000;
   localparam int  SETTLE  = 80;
   localparam int  NPHASES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   slew_duty_profile_controller_top dut (.*);

   always #5 clock = ~clock;

   // register shadow
   longint cfg_accel, cfg_min, cfg_max, cfg_tol, cfg_period, cfg_thresh;
   longint cfg_kick_duty, cfg_tries;
   // predictor state
   bit      slew_on, dir_neg, irq_seen;
   longint  start_ang, goal_ang, check_ang, prev_ang, prev_up;
   int      check_cnt, kicks_left;
   logic [1:0] prev_phase;
   logic [9:0] prev_duty;

   rsp_type duty_expect_q[$];
   int  errors = 0, n_items = 0, n_results = 0, n_kicks = 0, n_stops = 0;
   int  cycles = 0;
   bit  quiet_tx = 0, quiet_rx = 0;
   int  hold_cycles = 0;

   function automatic rsp_type mk(longint duty, bit on, logic [1:0] ph, bit kick,
                                  status_type st);
      rsp_type r;
      r.duty = duty[9:0];
      r.motor_on = on;
      r.direction_negative = dir_neg;
      r.phase = ph;
      r.destall = kick;
      r.status = st;
      return r;
   endfunction

   function automatic longint sat16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic longint rdiv(longint n, longint d);
      longint mag, q;
      mag = n < 0 ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return n < 0 ? -q : q;
   endfunction

   function automatic rsp_type idle_report();
      if (slew_on) return mk(prev_duty, 1, prev_phase, 0, ST_MOVING);
      return mk(0, 0, prev_phase, 0, ST_IDLE);
   endfunction

   function automatic rsp_type predict_duty(req_type r);
      longint tgt, ang, up, left, acc, span, base, nup, ndn, d, chg, mag;
      logic [1:0] ph;
      tgt = longint'(r.target_angle);
      ang = longint'(r.angle);
      if (r.kind == KIND_START) begin
         goal_ang = tgt; start_ang = ang; dir_neg = !(tgt > ang);
         check_ang = ang; check_cnt = 0; kicks_left = int'(cfg_tries);
         irq_seen = 0; prev_phase = PHASE_ACCEL; prev_ang = ang; prev_up = 0;
         prev_duty = 0; slew_on = 1;
         return mk(0, 1, PHASE_ACCEL, 0, ST_MOVING);
      end
      if (r.kind == KIND_INTERRUPT && slew_on) begin
         if (irq_seen) begin
            slew_on = 0;
            return mk(0, 0, prev_phase, 0, ST_EMERGENCY);
         end
         irq_seen = 1;
         if (prev_phase == PHASE_ACCEL)
            goal_ang = sat16(dir_neg ? prev_ang - prev_up : prev_ang + prev_up);
         else if (prev_phase == PHASE_PLATEAU)
            goal_ang = sat16(dir_neg ? prev_ang - cfg_accel : prev_ang + cfg_accel);
         return idle_report();
      end
      if (r.kind != KIND_SAMPLE || !slew_on) return idle_report();
      up   = dir_neg ? start_ang - ang : ang - start_ang;
      left = dir_neg ? ang - goal_ang : goal_ang - ang;
      acc  = cfg_accel == 0 ? 1 : cfg_accel;
      span = cfg_max - cfg_min;
      base = cfg_min * acc;
      if (left < cfg_tol) begin
         slew_on = 0;
         return mk(0, 0, prev_phase, 0, irq_seen ? ST_EARLY : ST_REACHED);
      end
      nup = up * span;
      ndn = (left - cfg_tol) * span;
      if (nup <= ndn) begin
         ph = PHASE_ACCEL; d = rdiv(nup + base, acc);
      end else begin
         ph = PHASE_DECEL; d = rdiv(ndn + base, acc);
      end
      if (d < cfg_min) d = cfg_min;
      else if (d >= cfg_max) begin
         ph = PHASE_PLATEAU; d = cfg_max;
      end
      prev_phase = ph; prev_ang = ang; prev_up = up; prev_duty = d[9:0];
      check_cnt = (check_cnt + 1) & 16'hFFFF;
      if (check_cnt >= cfg_period) begin
         chg = ang - check_ang;
         mag = chg < 0 ? -chg : chg;
         check_ang = ang; check_cnt = 0;
         if (mag < cfg_thresh) begin
            if (kicks_left > 0) begin
               kicks_left--;
               return mk(cfg_kick_duty, 1, ph, 1, ST_MOVING);
            end
            slew_on = 0;
            return mk(0, 0, prev_phase, 0, ST_STALLED);
         end
         if ((chg < 0) != dir_neg) begin
            slew_on = 0;
            return mk(0, 0, prev_phase, 0, ST_WRONG_DIR);
         end
         kicks_left = 0;
      end
      return mk(prev_duty, 1, ph, 0, ST_MOVING);
   endfunction

   task automatic csr_write(reg_index_type idx, longint val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val[31:0];
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_ACCEL_ANGLE:     cfg_accel = val & 16'h7FFF;
         REG_MIN_DUTY:        cfg_min = val & 10'h3FF;
         REG_MAX_DUTY:        cfg_max = val & 10'h3FF;
         REG_TOLERANCE:       cfg_tol = val & 16'h7FFF;
         REG_STALL_PERIOD:    cfg_period = val & 16'hFFFF;
         REG_STALL_THRESHOLD: cfg_thresh = val & 16'h7FFF;
         REG_DESTALL_DUTY:    cfg_kick_duty = val & 10'h3FF;
         REG_DESTALL_TRIES:   cfg_tries = val & 4'hF;
         default: begin
         end
      endcase
   endtask

   task automatic write_all(longint a, longint mn, longint mx, longint tl, longint pd,
                            longint th, longint kd, longint tr);
      csr_write(REG_ACCEL_ANGLE, a);
      csr_write(REG_MIN_DUTY, mn);
      csr_write(REG_MAX_DUTY, mx);
      csr_write(REG_TOLERANCE, tl);
      csr_write(REG_STALL_PERIOD, pd);
      csr_write(REG_STALL_THRESHOLD, th);
      csr_write(REG_DESTALL_DUTY, kd);
      csr_write(REG_DESTALL_TRIES, tr);
   endtask

   // one input transfer; expectation is the typed one if given
   task automatic send_item(req_type r, bit typed, rsp_type want);
      int gap;
      rsp_type p;
      gap = quiet_tx ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      p = predict_duty(r);
      duty_expect_q.insert(duty_expect_q.size(), typed ? want : p);
      n_items++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (duty_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type mkreq(logic [1:0] k, longint t, longint a);
      req_type r;
      r.kind = k;
      r.target_angle = t[15:0];
      r.angle = a[15:0];
      return r;
   endfunction

   task automatic random_slew();
      longint a, t, travel, step;
      int n, i, mode;
      req_type r;
      a = $signed($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 9) < 8) a = $signed($urandom_range(0, 8000)) - 4000;
      travel = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40000) : $urandom_range(0, 3000);
      t = sat16($urandom_range(0, 1) ? a + travel : a - travel);
      send_item(mkreq(KIND_START, t, a), 0, '0);
      n = $urandom_range(1, 40);
      mode = $urandom_range(0, 9);
      for (i = 0; i < n; i++) begin
         step = (travel / n) + $signed($urandom_range(0, 20)) - 10;
         if (mode == 0) step = 0;
         else if (mode == 1 && i > n / 2) step = -step;
         else if ($urandom_range(0, 15) == 0) step = $urandom_range(0, 3);
         a = sat16(t >= a ? a + step : a - step);
         if ($urandom_range(0, 25) == 0)
            send_item(mkreq(KIND_INTERRUPT, $urandom, $urandom), 0, '0);
         send_item(mkreq(KIND_SAMPLE, $urandom, a), 0, '0);
      end
   endtask

   // response side: random stalls, long hold on request, checking
   initial begin : rsp_side
      int n;
      rsp_type e;
      forever begin
         n = quiet_rx ? 0 : $urandom_range(0, 18);
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         n_results++;
         if (rsp_data.destall) n_kicks++;
         if (!rsp_data.motor_on && rsp_data.status != ST_IDLE) n_stops++;
         if (duty_expect_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response transfer %h", rsp_data);
         end else begin
            e = duty_expect_q.pop_front();
            if (rsp_data !== e) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch #%0d: exp duty=%0d on=%b neg=%b ph=%0d kick=%b st=%0d, got duty=%0d on=%b neg=%b ph=%0d kick=%b st=%0d",
                           n_results, e.duty, e.motor_on, e.direction_negative, e.phase,
                           e.destall, e.status, rsp_data.duty, rsp_data.motor_on,
                           rsp_data.direction_negative, rsp_data.phase, rsp_data.destall,
                           rsp_data.status);
            end
         end
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("slew_duty_profile_controller_top_tb: done, errors");
            $finish;
         end
      end
   end

   typedef struct {
      logic [1:0] kind;
      longint     tgt;
      longint     ang;
      bit         typed;
      rsp_type    want;
   } row_type;

   initial begin : main
      row_type tbl[$];
      int ph, k, i;
      cfg_accel = 640; cfg_min = 100; cfg_max = 1023; cfg_tol = 6;
      cfg_period = 100; cfg_thresh = 6; cfg_kick_duty = 1023; cfg_tries = 3;
      slew_on = 0; dir_neg = 0; irq_seen = 0; start_ang = 0; goal_ang = 0;
      check_ang = 0; prev_ang = 0; prev_up = 0; check_cnt = 0; kicks_left = 0;
      prev_phase = PHASE_ACCEL; prev_duty = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      tbl = '{
         '{KIND_SAMPLE, 0, 0, 1, '{0, 0, 0, PHASE_ACCEL, 0, ST_IDLE}},
         '{KIND_INTERRUPT, 0, 0, 1, '{0, 0, 0, PHASE_ACCEL, 0, ST_IDLE}},
         '{2'd3, -1, -1, 1, '{0, 0, 0, PHASE_ACCEL, 0, ST_IDLE}},
         '{KIND_START, 1000, 0, 1, '{0, 1, 0, PHASE_ACCEL, 0, ST_MOVING}},
         '{KIND_SAMPLE, 0, 0, 0, '0},
         '{KIND_SAMPLE, 0, 300, 0, '0},
         '{KIND_SAMPLE, 0, 700, 0, '0},
         '{KIND_INTERRUPT, 0, 0, 0, '0},
         '{KIND_SAMPLE, 0, 750, 0, '0},
         '{2'd3, 0, 0, 0, '0},
         '{KIND_INTERRUPT, 0, 0, 0, '0},
         '{KIND_START, -32768, 32767, 1, '{0, 1, 1, PHASE_ACCEL, 0, ST_MOVING}},
         '{KIND_SAMPLE, 0, 32767, 0, '0},
         '{KIND_SAMPLE, 0, 0, 0, '0},
         '{KIND_INTERRUPT, 0, 0, 0, '0},
         '{KIND_SAMPLE, 0, -32768, 0, '0},
         '{KIND_START, 5, 5, 1, '{0, 1, 1, PHASE_ACCEL, 0, ST_MOVING}},
         '{KIND_SAMPLE, 0, 5, 1, '{0, 0, 1, PHASE_ACCEL, 0, ST_REACHED}},
         '{KIND_START, 32767, -32768, 1, '{0, 1, 0, PHASE_ACCEL, 0, ST_MOVING}},
         '{KIND_SAMPLE, 0, -32768, 0, '0},
         '{KIND_SAMPLE, 0, 0, 0, '0},
         '{KIND_START, 0, 100, 0, '0},
         '{KIND_START, 100, 0, 0, '0},
         '{KIND_SAMPLE, 0, 96, 0, '0}
      };
      foreach (tbl[j])
         send_item(mkreq(tbl[j].kind, tbl[j].tgt, tbl[j].ang), tbl[j].typed, tbl[j].want);
      drain();

      for (ph = 0; ph < NPHASES; ph++) begin
         case (ph)
            0: write_all(1, 0, 1023, 0, 1, 0, 0, 0);
            1: write_all(32767, 1023, 0, 32767, 65535, 32767, 1023, 15);
            2: write_all(640, 100, 1023, 6, 100, 6, 1023, 3);
            default: write_all($urandom_range(1, 2000), $urandom_range(0, 300),
                               $urandom_range(500, 1023), $urandom_range(0, 20),
                               $urandom_range(1, 20), $urandom_range(0, 12),
                               $urandom_range(0, 1023), $urandom_range(0, 15));
         endcase
         quiet_tx = (ph == 3);
         quiet_rx = (ph == 4);
         k = n_items + 210;
         i = 0;
         while (n_items < k) begin
            if (ph == 5 && i == 3) hold_cycles = 2000;
            if ($urandom_range(0, 9) == 0)
               send_item(mkreq(2'($urandom_range(0, 3)), $urandom, $urandom), 0, '0);
            else
               random_slew();
            i++;
         end
         drain();
      end

      $display("%0d items sent, %0d responses checked over %0d register settings",
               n_items, n_results, NPHASES + 1);
      $display("%0d de-stall kicks and %0d stops seen", n_kicks, n_stops);
      if (errors == 0)
         $display("slew_duty_profile_controller_top_tb: done, clean");
      else
         $display("slew_duty_profile_controller_top_tb: done, errors");
      $finish;
   end
endmodule
